// ===== hdl/glr_pkg.sv =====
// ============================================================================
// glr_pkg: shared types and constants for the glyph run layout block
// Field widths, character codes, register indexes, the character class and
// the vertex step sequence used by the front end, back end and top level.
// ============================================================================
package glr_pkg;

    // Field widths of the input item, the result item and the registers.
    localparam int CODE_W      = 8;
    localparam int OFS_W       = 16;
    localparam int SIZE_W      = 15;
    localparam int TEX_W       = 12;
    localparam int UV_W        = 13;
    localparam int ADV_W       = 16;
    localparam int CHAR_SIZE_W = 10;
    localparam int SPACE_W     = 16;
    localparam int LINE_W      = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    // A tab advances by four space widths.
    localparam int TAB_SHIFT = 2;

    // Character codes that move the pen without drawing.
    localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [CODE_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;

    // Register values after reset.
    localparam logic [CHAR_SIZE_W-1:0] CHAR_SIZE_RESET = 10'd16;
    localparam logic [SPACE_W-1:0]     SPACE_RESET     = 16'd256;
    localparam logic [LINE_W-1:0]      LINE_RESET      = 17'd1216;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHAR_SIZE     = 2'd0,
        REG_SPACE_ADVANCE = 2'd1,
        REG_LINE_SPACING  = 2'd2
    } cfg_reg_t;

    // Character class decided by the front end.
    typedef enum logic [1:0] {
        CLS_GLYPH,
        CLS_SPACE,
        CLS_TAB,
        CLS_NEWLINE
    } char_class_t;

    // Output sequence of the back end: two triangles, then the bounds record.
    typedef enum logic [2:0] {
        STEP_TL,
        STEP_TR,
        STEP_BL,
        STEP_BL_DUP,
        STEP_TR_DUP,
        STEP_BR,
        STEP_BOUNDS
    } vtx_step_t;

    // Sort a character byte into its class.
    function automatic char_class_t classify(input logic [CODE_W-1:0] code);
        char_class_t cls;
        case (code)
            CHAR_SPACE:   cls = CLS_SPACE;
            CHAR_TAB:     cls = CLS_TAB;
            CHAR_NEWLINE: cls = CLS_NEWLINE;
            default:      cls = CLS_GLYPH;
        endcase
        return cls;
    endfunction

endpackage

// ===== hdl/glr_fifo.sv =====
// ============================================================================
// glr_fifo: small queue between the layout front end and back end
// First-word-fall-through queue; the head entry is visible while valid.
// ============================================================================
module glr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;
    logic             full;
    logic             empty;
    logic             push;
    logic             pop;

    // Full when the pointers differ only in the wrap bit.
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);

    assign in_ready  = !full;
    assign out_valid = !empty;
    assign push      = in_valid && !full;
    assign pop       = out_ready && !empty;
    assign out_data  = entry_reg[rd_ptr_reg[AW-1:0]];

    // Pointer advance.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Entry storage is written on each accepted transfer.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg[AW-1:0]] <= in_data;
        end
    end

endmodule

// ===== hdl/glr_front.sv =====
// ============================================================================
// glr_front: character intake and pen tracking
// Takes one character, applies kerning, classifies it, moves the pen and
// hands a work entry (quad corners or bounds candidates) to the queue.
// ============================================================================
module glr_front #(
    parameter int                            COORD_WIDTH = 24,
    parameter logic signed [COORD_WIDTH-1:0] RESET_COORD = '0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [glr_pkg::CODE_W-1:0]           s_char_code,
    input  logic signed [glr_pkg::OFS_W-1:0]     s_kerning,
    input  logic signed [glr_pkg::OFS_W-1:0]     s_glyph_left,
    input  logic signed [glr_pkg::OFS_W-1:0]     s_glyph_top,
    input  logic [glr_pkg::SIZE_W-1:0]           s_glyph_width,
    input  logic [glr_pkg::SIZE_W-1:0]           s_glyph_height,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_left,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_top,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_width,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_height,
    input  logic [glr_pkg::ADV_W-1:0]            s_glyph_advance,
    input  logic                                 s_last_char,
    input  logic [glr_pkg::SPACE_W-1:0]          space_advance,
    input  logic [glr_pkg::LINE_W-1:0]           line_spacing,
    input  logic signed [COORD_WIDTH-1:0]        reset_coord,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output logic [4*COORD_WIDTH+4*glr_pkg::UV_W+1:0] q_data
);
    import glr_pkg::*;

    // Working width leaves headroom for every sum before saturation.
    localparam int WW = COORD_WIDTH + 4;
    localparam logic signed [WW-1:0] SAT_MAX = {{5{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [WW-1:0] SAT_MIN = {{5{1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                          glyph;
        logic                          last;
        logic signed [COORD_WIDTH-1:0] x_lo;
        logic signed [COORD_WIDTH-1:0] y_lo;
        logic signed [COORD_WIDTH-1:0] x_hi;
        logic signed [COORD_WIDTH-1:0] y_hi;
        logic [UV_W-1:0]               u1;
        logic [UV_W-1:0]               v1;
        logic [UV_W-1:0]               u2;
        logic [UV_W-1:0]               v2;
    } entry_t;

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [WW-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[COORD_WIDTH-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[COORD_WIDTH-1:0];
        end else begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WW-1:0] ext_coord(
        input logic signed [COORD_WIDTH-1:0] c
    );
        return {{(WW-COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
    endfunction

    // Held character, filled at intake and retired when the queue takes its entry.
    logic                          busy_reg;
    logic                          busy_next;
    char_class_t                   cls_reg;
    logic signed [COORD_WIDTH-1:0] px1_reg;
    logic signed [OFS_W-1:0]       gl_reg;
    logic signed [OFS_W-1:0]       gt_reg;
    logic signed [OFS_W:0]         glw_reg;
    logic signed [OFS_W:0]         gth_reg;
    logic [ADV_W-1:0]              adv_reg;
    logic [UV_W-1:0]               u1_reg;
    logic [UV_W-1:0]               v1_reg;
    logic [UV_W-1:0]               u2_reg;
    logic [UV_W-1:0]               v2_reg;
    logic                          last_reg;

    // Pen position.
    logic signed [COORD_WIDTH-1:0] pen_x_reg;
    logic signed [COORD_WIDTH-1:0] pen_x_next;
    logic signed [COORD_WIDTH-1:0] pen_y_reg;
    logic signed [COORD_WIDTH-1:0] pen_y_next;

    logic                          accept;
    logic                          push;
    logic signed [COORD_WIDTH-1:0] px1_in;
    logic signed [OFS_W:0]         glw_in;
    logic signed [OFS_W:0]         gth_in;
    logic signed [WW-1:0]          pxa;
    logic signed [WW-1:0]          pya;
    logic signed [COORD_WIDTH-1:0] pxn;
    logic signed [COORD_WIDTH-1:0] pyn;
    entry_t                        entry;

    // One character is held until the queue takes its entry: kerning first, then the move.
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign q_valid = busy_reg;
    assign push    = busy_reg && q_ready;

    // Intake: kerned pen position and the far box edges relative to the pen.
    always_comb begin
        px1_in = sat_coord(ext_coord(pen_x_reg) +
                           {{(WW-OFS_W){s_kerning[OFS_W-1]}}, s_kerning});
        glw_in = $signed({s_glyph_left[OFS_W-1], s_glyph_left}) +
                 $signed({2'b00, s_glyph_width});
        gth_in = $signed({s_glyph_top[OFS_W-1], s_glyph_top}) +
                 $signed({2'b00, s_glyph_height});
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cls_reg  <= classify(s_char_code);
            px1_reg  <= px1_in;
            gl_reg   <= s_glyph_left;
            gt_reg   <= s_glyph_top;
            glw_reg  <= glw_in;
            gth_reg  <= gth_in;
            adv_reg  <= s_glyph_advance;
            u1_reg   <= {1'b0, s_tex_left};
            v1_reg   <= {1'b0, s_tex_top};
            u2_reg   <= {1'b0, s_tex_left} + {1'b0, s_tex_width};
            v2_reg   <= {1'b0, s_tex_top} + {1'b0, s_tex_height};
            last_reg <= s_last_char;
        end
    end

    // Hold stage: move the pen and build the work entry.
    always_comb begin
        pxa         = ext_coord(px1_reg);
        pya         = ext_coord(pen_y_reg);
        pxn         = px1_reg;
        pyn         = pen_y_reg;
        entry       = '0;
        entry.last  = last_reg;
        entry.glyph = 1'b0;
        entry.x_lo  = px1_reg;
        entry.y_lo  = pen_y_reg;
        case (cls_reg)
            CLS_SPACE: begin
                pxn = sat_coord(pxa + {{(WW-SPACE_W){1'b0}}, space_advance});
            end
            CLS_TAB: begin
                pxn = sat_coord(pxa +
                      ({{(WW-SPACE_W){1'b0}}, space_advance} <<< TAB_SHIFT));
            end
            CLS_NEWLINE: begin
                pxn = '0;
                pyn = sat_coord(pya + {{(WW-LINE_W){1'b0}}, line_spacing});
            end
            default: begin
                pxn         = sat_coord(pxa + {{(WW-ADV_W){1'b0}}, adv_reg});
                entry.glyph = 1'b1;
                entry.x_lo  = sat_coord(pxa + {{(WW-OFS_W){gl_reg[OFS_W-1]}}, gl_reg});
                entry.y_lo  = sat_coord(pya + {{(WW-OFS_W){gt_reg[OFS_W-1]}}, gt_reg});
                entry.u1    = u1_reg;
                entry.v1    = v1_reg;
                entry.u2    = u2_reg;
                entry.v2    = v2_reg;
            end
        endcase
        // Specials report the pen after the move as their upper bound.
        if (cls_reg == CLS_GLYPH) begin
            entry.x_hi = sat_coord(pxa + {{(WW-OFS_W-1){glw_reg[OFS_W]}}, glw_reg});
            entry.y_hi = sat_coord(pya + {{(WW-OFS_W-1){gth_reg[OFS_W]}}, gth_reg});
        end else begin
            entry.x_hi = pxn;
            entry.y_hi = pyn;
        end
    end

    assign q_data = entry;

    // Pen and hold state; the string end puts the pen back at its start.
    always_comb begin
        busy_next  = busy_reg;
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (push) begin
            busy_next = 1'b0;
            if (last_reg) begin
                pen_x_next = '0;
                pen_y_next = reset_coord;
            end else begin
                pen_x_next = pxn;
                pen_y_next = pyn;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pen_x_reg <= '0;
            pen_y_reg <= RESET_COORD;
        end else begin
            busy_reg  <= busy_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

// ===== hdl/glr_back.sv =====
// ============================================================================
// glr_back: vertex and bounds record generator
// Takes work entries from the queue, keeps the running bounds and emits six
// vertex records per glyph and a bounds record at the end of the string.
// ============================================================================
module glr_back #(
    parameter int                            COORD_WIDTH = 24,
    parameter logic signed [COORD_WIDTH-1:0] RESET_COORD = '0
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     q_valid,
    output logic                                     q_ready,
    input  logic [4*COORD_WIDTH+4*glr_pkg::UV_W+1:0] q_data,
    input  logic signed [COORD_WIDTH-1:0]            reset_coord,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [COORD_WIDTH-1:0]            m_vertex_x,
    output logic signed [COORD_WIDTH-1:0]            m_vertex_y,
    output logic [glr_pkg::UV_W-1:0]                 m_tex_u,
    output logic [glr_pkg::UV_W-1:0]                 m_tex_v,
    output logic                                     m_is_bounds,
    output logic signed [COORD_WIDTH-1:0]            m_bound_x,
    output logic signed [COORD_WIDTH-1:0]            m_bound_y,
    output logic signed [COORD_WIDTH-1:0]            m_bound_w,
    output logic signed [COORD_WIDTH-1:0]            m_bound_h,
    output logic                                     m_last_of_run
);
    import glr_pkg::*;

    localparam int WW = COORD_WIDTH + 4;
    localparam logic signed [WW-1:0] SAT_MAX = {{5{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [WW-1:0] SAT_MIN = {{5{1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                          glyph;
        logic                          last;
        logic signed [COORD_WIDTH-1:0] x_lo;
        logic signed [COORD_WIDTH-1:0] y_lo;
        logic signed [COORD_WIDTH-1:0] x_hi;
        logic signed [COORD_WIDTH-1:0] y_hi;
        logic [UV_W-1:0]               u1;
        logic [UV_W-1:0]               v1;
        logic [UV_W-1:0]               u2;
        logic [UV_W-1:0]               v2;
    } entry_t;

    function automatic logic signed [COORD_WIDTH-1:0] sat_diff(
        input logic signed [COORD_WIDTH-1:0] hi,
        input logic signed [COORD_WIDTH-1:0] lo
    );
        logic signed [WW-1:0]          d;
        logic signed [COORD_WIDTH-1:0] r;
        d = {{(WW-COORD_WIDTH){hi[COORD_WIDTH-1]}}, hi} -
            {{(WW-COORD_WIDTH){lo[COORD_WIDTH-1]}}, lo};
        if (d > SAT_MAX) begin
            r = SAT_MAX[COORD_WIDTH-1:0];
        end else if (d < SAT_MIN) begin
            r = SAT_MIN[COORD_WIDTH-1:0];
        end else begin
            r = d[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    entry_t                        q_entry;
    entry_t                        cur_reg;
    entry_t                        cur_next;
    logic                          cur_valid_reg;
    logic                          cur_valid_next;
    vtx_step_t                     step_reg;
    vtx_step_t                     step_next;

    logic signed [COORD_WIDTH-1:0] min_x_reg;
    logic signed [COORD_WIDTH-1:0] min_y_reg;
    logic signed [COORD_WIDTH-1:0] max_x_reg;
    logic signed [COORD_WIDTH-1:0] max_y_reg;
    logic signed [COORD_WIDTH-1:0] min_x_next;
    logic signed [COORD_WIDTH-1:0] min_y_next;
    logic signed [COORD_WIDTH-1:0] max_x_next;
    logic signed [COORD_WIDTH-1:0] max_y_next;
    logic signed [COORD_WIDTH-1:0] base_min_x;
    logic signed [COORD_WIDTH-1:0] base_min_y;
    logic signed [COORD_WIDTH-1:0] base_max_x;
    logic signed [COORD_WIDTH-1:0] base_max_y;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic signed [COORD_WIDTH-1:0] vx_reg;
    logic signed [COORD_WIDTH-1:0] vy_reg;
    logic [UV_W-1:0]               u_reg;
    logic [UV_W-1:0]               v_reg;
    logic                          is_bounds_reg;
    logic signed [COORD_WIDTH-1:0] bx_reg;
    logic signed [COORD_WIDTH-1:0] by_reg;
    logic signed [COORD_WIDTH-1:0] bw_reg;
    logic signed [COORD_WIDTH-1:0] bh_reg;
    logic                          lor_reg;

    logic signed [COORD_WIDTH-1:0] rec_vx;
    logic signed [COORD_WIDTH-1:0] rec_vy;
    logic [UV_W-1:0]               rec_u;
    logic [UV_W-1:0]               rec_v;
    logic                          rec_bounds;
    logic                          rec_lor;

    logic                          out_free;
    logic                          emit;
    logic                          cur_done;
    logic                          take;
    logic                          pop;
    logic                          bnd_clear;

    assign q_entry = entry_t'(q_data);

    // Handshake between queue, current entry and output register.
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = cur_valid_reg && out_free;
    assign cur_done  = emit && (((step_reg == STEP_BR) && !cur_reg.last) ||
                                (step_reg == STEP_BOUNDS));
    assign take      = !cur_valid_reg || cur_done;
    assign q_ready   = take;
    assign pop       = q_valid && take;
    assign bnd_clear = emit && (step_reg == STEP_BOUNDS);

    // Step sequencing of the current entry.
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (pop) begin
            cur_next = q_entry;
            if (q_entry.glyph) begin
                cur_valid_next = 1'b1;
                step_next      = STEP_TL;
            end else begin
                // A special character only produces a record at string end.
                cur_valid_next = q_entry.last;
                step_next      = STEP_BOUNDS;
            end
        end else if (cur_done) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            case (step_reg)
                STEP_TL:     step_next = STEP_TR;
                STEP_TR:     step_next = STEP_BL;
                STEP_BL:     step_next = STEP_BL_DUP;
                STEP_BL_DUP: step_next = STEP_TR_DUP;
                STEP_TR_DUP: step_next = STEP_BR;
                default:     step_next = STEP_BOUNDS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_TL;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
        end
    end

    // Running bounds: cleared after the bounds record, widened on each entry.
    always_comb begin
        if (bnd_clear) begin
            base_min_x = reset_coord;
            base_min_y = reset_coord;
            base_max_x = '0;
            base_max_y = '0;
        end else begin
            base_min_x = min_x_reg;
            base_min_y = min_y_reg;
            base_max_x = max_x_reg;
            base_max_y = max_y_reg;
        end
        min_x_next = base_min_x;
        min_y_next = base_min_y;
        max_x_next = base_max_x;
        max_y_next = base_max_y;
        if (pop) begin
            min_x_next = (q_entry.x_lo < base_min_x) ? q_entry.x_lo : base_min_x;
            min_y_next = (q_entry.y_lo < base_min_y) ? q_entry.y_lo : base_min_y;
            max_x_next = (q_entry.x_hi > base_max_x) ? q_entry.x_hi : base_max_x;
            max_y_next = (q_entry.y_hi > base_max_y) ? q_entry.y_hi : base_max_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= RESET_COORD;
            min_y_reg <= RESET_COORD;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end else begin
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

    // Record selection: corner order TL, TR, BL, BL, TR, BR.
    always_comb begin
        rec_vx     = cur_reg.x_lo;
        rec_vy     = cur_reg.y_lo;
        rec_u      = cur_reg.u1;
        rec_v      = cur_reg.v1;
        rec_bounds = 1'b0;
        rec_lor    = 1'b0;
        case (step_reg)
            STEP_TL: begin
                rec_vx = cur_reg.x_lo;
                rec_vy = cur_reg.y_lo;
            end
            STEP_TR, STEP_TR_DUP: begin
                rec_vx = cur_reg.x_hi;
                rec_u  = cur_reg.u2;
            end
            STEP_BL, STEP_BL_DUP: begin
                rec_vy = cur_reg.y_hi;
                rec_v  = cur_reg.v2;
            end
            STEP_BR: begin
                rec_vx  = cur_reg.x_hi;
                rec_vy  = cur_reg.y_hi;
                rec_u   = cur_reg.u2;
                rec_v   = cur_reg.v2;
                rec_lor = !cur_reg.last;
            end
            default: begin
                rec_vx     = '0;
                rec_vy     = '0;
                rec_u      = '0;
                rec_v      = '0;
                rec_bounds = 1'b1;
                rec_lor    = 1'b1;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            vx_reg        <= rec_vx;
            vy_reg        <= rec_vy;
            u_reg         <= rec_u;
            v_reg         <= rec_v;
            is_bounds_reg <= rec_bounds;
            lor_reg       <= rec_lor;
            if (rec_bounds) begin
                bx_reg <= min_x_reg;
                by_reg <= min_y_reg;
                bw_reg <= sat_diff(max_x_reg, min_x_reg);
                bh_reg <= sat_diff(max_y_reg, min_y_reg);
            end else begin
                bx_reg <= '0;
                by_reg <= '0;
                bw_reg <= '0;
                bh_reg <= '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_vertex_x    = vx_reg;
    assign m_vertex_y    = vy_reg;
    assign m_tex_u       = u_reg;
    assign m_tex_v       = v_reg;
    assign m_is_bounds   = is_bounds_reg;
    assign m_bound_x     = bx_reg;
    assign m_bound_y     = by_reg;
    assign m_bound_w     = bw_reg;
    assign m_bound_h     = bh_reg;
    assign m_last_of_run = lor_reg;

endmodule

// ===== hdl/glyph_run_layout.sv =====
// ============================================================================
// glyph_run_layout: text string layout into textured quads
// Records of a character pass the front end hold, the work queue, the back end
// current entry and the output register. One record per cycle while m_ready is
// high; a glyph gives six vertex records, plus a bounds record if it ends the
// string. The front end holds one character at a time: kerning, then advance add.
// Reset is synchronous: pen, bounds and registers return to their defaults.
// ============================================================================
module glyph_run_layout #(
    parameter int FRAC_BITS   = 6,
    parameter int COORD_WIDTH = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [glr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [glr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [glr_pkg::CODE_W-1:0]           s_char_code,
    input  logic signed [glr_pkg::OFS_W-1:0]     s_kerning,
    input  logic signed [glr_pkg::OFS_W-1:0]     s_glyph_left,
    input  logic signed [glr_pkg::OFS_W-1:0]     s_glyph_top,
    input  logic [glr_pkg::SIZE_W-1:0]           s_glyph_width,
    input  logic [glr_pkg::SIZE_W-1:0]           s_glyph_height,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_left,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_top,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_width,
    input  logic [glr_pkg::TEX_W-1:0]            s_tex_height,
    input  logic [glr_pkg::ADV_W-1:0]            s_glyph_advance,
    input  logic                                 s_last_char,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [COORD_WIDTH-1:0]        m_vertex_x,
    output logic signed [COORD_WIDTH-1:0]        m_vertex_y,
    output logic [glr_pkg::UV_W-1:0]             m_tex_u,
    output logic [glr_pkg::UV_W-1:0]             m_tex_v,
    output logic                                 m_is_bounds,
    output logic signed [COORD_WIDTH-1:0]        m_bound_x,
    output logic signed [COORD_WIDTH-1:0]        m_bound_y,
    output logic signed [COORD_WIDTH-1:0]        m_bound_w,
    output logic signed [COORD_WIDTH-1:0]        m_bound_h,
    output logic                                 m_last_of_run
);
    import glr_pkg::*;

    localparam int ENTRY_W = 4 * COORD_WIDTH + 4 * UV_W + 2;

    // Start baseline for the reset value of the character size, saturated.
    localparam longint C_RAW = longint'(CHAR_SIZE_RESET) << FRAC_BITS;
    localparam longint C_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint C_SAT = (C_RAW > C_MAX) ? C_MAX : C_RAW;
    localparam logic signed [COORD_WIDTH-1:0] RESET_COORD = COORD_WIDTH'(C_SAT);

    logic [CHAR_SIZE_W-1:0]        char_size_reg;
    logic [SPACE_W-1:0]            space_advance_reg;
    logic [LINE_W-1:0]             line_spacing_reg;
    logic [COORD_WIDTH-1:0]        size_shifted;
    logic                          size_over;
    logic signed [COORD_WIDTH-1:0] reset_coord;

    logic                          fq_valid;
    logic                          fq_ready;
    logic [ENTRY_W-1:0]            fq_data;
    logic                          bq_valid;
    logic                          bq_ready;
    logic [ENTRY_W-1:0]            bq_data;

    // Configuration registers; every write transfer is taken at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_size_reg     <= CHAR_SIZE_RESET;
            space_advance_reg <= SPACE_RESET;
            line_spacing_reg  <= LINE_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_CHAR_SIZE:     char_size_reg     <= cfg_data[CHAR_SIZE_W-1:0];
                REG_SPACE_ADVANCE: space_advance_reg <= cfg_data[SPACE_W-1:0];
                REG_LINE_SPACING:  line_spacing_reg  <= cfg_data[LINE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Start baseline from the current character size, saturated.
    assign size_shifted = COORD_WIDTH'(char_size_reg) << FRAC_BITS;
    assign size_over    = (char_size_reg >> (COORD_WIDTH - 1 - FRAC_BITS)) != '0;
    assign reset_coord  = size_over ? {1'b0, {(COORD_WIDTH-1){1'b1}}} : size_shifted;

    // Front end: intake, classification and pen movement.
    glr_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .RESET_COORD (RESET_COORD)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_kerning       (s_kerning),
        .s_glyph_left    (s_glyph_left),
        .s_glyph_top     (s_glyph_top),
        .s_glyph_width   (s_glyph_width),
        .s_glyph_height  (s_glyph_height),
        .s_tex_left      (s_tex_left),
        .s_tex_top       (s_tex_top),
        .s_tex_width     (s_tex_width),
        .s_tex_height    (s_tex_height),
        .s_glyph_advance (s_glyph_advance),
        .s_last_char     (s_last_char),
        .space_advance   (space_advance_reg),
        .line_spacing    (line_spacing_reg),
        .reset_coord     (reset_coord),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_data          (fq_data)
    );

    // Work queue between the two halves.
    glr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    // Back end: record generation and running bounds.
    glr_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .RESET_COORD (RESET_COORD)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (bq_valid),
        .q_ready       (bq_ready),
        .q_data        (bq_data),
        .reset_coord   (reset_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex_x    (m_vertex_x),
        .m_vertex_y    (m_vertex_y),
        .m_tex_u       (m_tex_u),
        .m_tex_v       (m_tex_v),
        .m_is_bounds   (m_is_bounds),
        .m_bound_x     (m_bound_x),
        .m_bound_y     (m_bound_y),
        .m_bound_w     (m_bound_w),
        .m_bound_h     (m_bound_h),
        .m_last_of_run (m_last_of_run)
    );

    // The front end takes no new character while it still holds one.
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front end took a character while still holding one");

    // A bounds record always closes the results of its character.
    a_bounds_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_bounds |-> m_last_of_run)
        else $error("bounds record without last_of_run");

    // After reset no record is pending and the front end is open.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

// ===== bench/tb_top.sv =====
// ============================================================================
// tb_top: self-checking bench for glyph_run_layout
// Drives characters of text strings through the input channel and register
// writes through the configuration port, lays out each accepted character in
// a behavioral copy of the pen and bounds logic, and compares every vertex
// and bounds record on the output channel field by field, in order.
// ============================================================================
module tb_top;

    import glr_pkg::*;

    localparam int COORD_W        = 24;
    localparam int FRAC           = 6;
    localparam int TAB_STOPS      = 4;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // Register index that decodes to no register.
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

    // One character as it arrives from the font store.
    typedef struct {
        logic [CODE_W-1:0]       code;
        logic signed [OFS_W-1:0] kerning;
        logic signed [OFS_W-1:0] glyph_left;
        logic signed [OFS_W-1:0] glyph_top;
        logic [SIZE_W-1:0]       glyph_width;
        logic [SIZE_W-1:0]       glyph_height;
        logic [TEX_W-1:0]        tex_left;
        logic [TEX_W-1:0]        tex_top;
        logic [TEX_W-1:0]        tex_width;
        logic [TEX_W-1:0]        tex_height;
        logic [ADV_W-1:0]        advance;
        logic                    last;
    } glyph_char_t;

    // One vertex or bounds record on the output channel.
    typedef struct {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [UV_W-1:0]           tex_u;
        logic [UV_W-1:0]           tex_v;
        logic                      is_bounds;
        logic signed [COORD_W-1:0] bound_x;
        logic signed [COORD_W-1:0] bound_y;
        logic signed [COORD_W-1:0] bound_w;
        logic signed [COORD_W-1:0] bound_h;
        logic                      last_of_run;
    } layout_rec_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [CODE_W-1:0]         s_char_code;
    logic signed [OFS_W-1:0]   s_kerning;
    logic signed [OFS_W-1:0]   s_glyph_left;
    logic signed [OFS_W-1:0]   s_glyph_top;
    logic [SIZE_W-1:0]         s_glyph_width;
    logic [SIZE_W-1:0]         s_glyph_height;
    logic [TEX_W-1:0]          s_tex_left;
    logic [TEX_W-1:0]          s_tex_top;
    logic [TEX_W-1:0]          s_tex_width;
    logic [TEX_W-1:0]          s_tex_height;
    logic [ADV_W-1:0]          s_glyph_advance;
    logic                      s_last_char;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COORD_W-1:0] m_vertex_x;
    logic signed [COORD_W-1:0] m_vertex_y;
    logic [UV_W-1:0]           m_tex_u;
    logic [UV_W-1:0]           m_tex_v;
    logic                      m_is_bounds;
    logic signed [COORD_W-1:0] m_bound_x;
    logic signed [COORD_W-1:0] m_bound_y;
    logic signed [COORD_W-1:0] m_bound_w;
    logic signed [COORD_W-1:0] m_bound_h;
    logic                      m_last_of_run;

    // Register copies and layout state of the behavioral model.
    logic [CHAR_SIZE_W-1:0] char_size_q;
    logic [SPACE_W-1:0]     space_adv_q;
    logic [LINE_W-1:0]      line_step_q;
    longint pen_x, pen_y, box_min_x, box_min_y, box_max_x, box_max_y;

    layout_rec_t expected_records[$];
    int          fail_count   = 0;
    bit          send_burst   = 1'b0;
    int          hold_request = 0;

    glyph_run_layout #(
        .FRAC_BITS   (FRAC),
        .COORD_WIDTH (COORD_W)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_kerning       (s_kerning),
        .s_glyph_left    (s_glyph_left),
        .s_glyph_top     (s_glyph_top),
        .s_glyph_width   (s_glyph_width),
        .s_glyph_height  (s_glyph_height),
        .s_tex_left      (s_tex_left),
        .s_tex_top       (s_tex_top),
        .s_tex_width     (s_tex_width),
        .s_tex_height    (s_tex_height),
        .s_glyph_advance (s_glyph_advance),
        .s_last_char     (s_last_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_x      (m_vertex_x),
        .m_vertex_y      (m_vertex_y),
        .m_tex_u         (m_tex_u),
        .m_tex_v         (m_tex_v),
        .m_is_bounds     (m_is_bounds),
        .m_bound_x       (m_bound_x),
        .m_bound_y       (m_bound_y),
        .m_bound_w       (m_bound_w),
        .m_bound_h       (m_bound_h),
        .m_last_of_run   (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Layout model
    // ------------------------------------------------------------------------

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Start of a string: baseline and minimum bounds at the character size.
    function automatic void restart_layout();
        longint base;
        base = clamp_coord(longint'(char_size_q) <<< FRAC);
        pen_x     = 0;
        pen_y     = base;
        box_min_x = base;
        box_min_y = base;
        box_max_x = 0;
        box_max_y = 0;
    endfunction

    function automatic void push_vertex(input longint x, input longint y,
                                        input logic [UV_W-1:0] u,
                                        input logic [UV_W-1:0] v,
                                        input logic last);
        layout_rec_t r;
        r = '{default: '0};
        r.vertex_x    = x[COORD_W-1:0];
        r.vertex_y    = y[COORD_W-1:0];
        r.tex_u       = u;
        r.tex_v       = v;
        r.last_of_run = last;
        expected_records.push_back(r);
    endfunction

    // Advance the pen for one character and queue the records it produces.
    function automatic void layout_char(input glyph_char_t c);
        longint xl, xr, yt, yb, span_w, span_h;
        logic [UV_W-1:0] u1, v1, u2, v2;
        layout_rec_t b;

        pen_x = clamp_coord(pen_x + longint'(c.kerning));

        if (c.code == CHAR_SPACE || c.code == CHAR_TAB || c.code == CHAR_NEWLINE) begin
            // Whitespace: minimum from the pen before the move, maximum after.
            if (pen_x < box_min_x) box_min_x = pen_x;
            if (pen_y < box_min_y) box_min_y = pen_y;
            case (c.code)
                CHAR_SPACE: pen_x = clamp_coord(pen_x + longint'(space_adv_q));
                CHAR_TAB: pen_x = clamp_coord(pen_x + longint'(space_adv_q) * TAB_STOPS);
                default: begin
                    pen_y = clamp_coord(pen_y + longint'(line_step_q));
                    pen_x = 0;
                end
            endcase
            if (pen_x > box_max_x) box_max_x = pen_x;
            if (pen_y > box_max_y) box_max_y = pen_y;
        end else begin
            // Drawn glyph: quad corners, then two triangles TL TR BL, BL TR BR.
            xl = clamp_coord(pen_x + longint'(c.glyph_left));
            xr = clamp_coord(pen_x + longint'(c.glyph_left) + longint'(c.glyph_width));
            yt = clamp_coord(pen_y + longint'(c.glyph_top));
            yb = clamp_coord(pen_y + longint'(c.glyph_top) + longint'(c.glyph_height));
            u1 = {1'b0, c.tex_left};
            v1 = {1'b0, c.tex_top};
            u2 = u1 + {1'b0, c.tex_width};
            v2 = v1 + {1'b0, c.tex_height};
            push_vertex(xl, yt, u1, v1, 1'b0);
            push_vertex(xr, yt, u2, v1, 1'b0);
            push_vertex(xl, yb, u1, v2, 1'b0);
            push_vertex(xl, yb, u1, v2, 1'b0);
            push_vertex(xr, yt, u2, v1, 1'b0);
            push_vertex(xr, yb, u2, v2, !c.last);
            if (xl < box_min_x) box_min_x = xl;
            if (xr > box_max_x) box_max_x = xr;
            if (yt < box_min_y) box_min_y = yt;
            if (yb > box_max_y) box_max_y = yb;
            pen_x = clamp_coord(pen_x + longint'(c.advance));
        end

        // The final character closes the string with its bounds.
        if (c.last) begin
            span_w        = clamp_coord(box_max_x - box_min_x);
            span_h        = clamp_coord(box_max_y - box_min_y);
            b             = '{default: '0};
            b.is_bounds   = 1'b1;
            b.bound_x     = box_min_x[COORD_W-1:0];
            b.bound_y     = box_min_y[COORD_W-1:0];
            b.bound_w     = span_w[COORD_W-1:0];
            b.bound_h     = span_h[COORD_W-1:0];
            b.last_of_run = 1'b1;
            expected_records.push_back(b);
            restart_layout();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic glyph_char_t make_char(input logic [CODE_W-1:0] code,
                                              input int kern, input int left,
                                              input int top, input int width,
                                              input int height, input int tl,
                                              input int tt, input int tw,
                                              input int th, input int adv,
                                              input logic last);
        glyph_char_t c;
        c.code         = code;
        c.kerning      = kern[OFS_W-1:0];
        c.glyph_left   = left[OFS_W-1:0];
        c.glyph_top    = top[OFS_W-1:0];
        c.glyph_width  = width[SIZE_W-1:0];
        c.glyph_height = height[SIZE_W-1:0];
        c.tex_left     = tl[TEX_W-1:0];
        c.tex_top      = tt[TEX_W-1:0];
        c.tex_width    = tw[TEX_W-1:0];
        c.tex_height   = th[TEX_W-1:0];
        c.advance      = adv[ADV_W-1:0];
        c.last         = last;
        return c;
    endfunction

    // A random field value of the given width, often at one of its extremes.
    function automatic logic [15:0] pick_field(input int width);
        logic [15:0] mask, v;
        mask = 16'hFFFF >> (16 - width);
        case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = mask;
            2:       v = mask >> 1;
            3:       v = ~(mask >> 1);
            default: v = 16'($urandom);
        endcase
        return v & mask;
    endfunction

    function automatic glyph_char_t rand_char(input logic last);
        glyph_char_t c;
        case ($urandom_range(0, 9))
            0:       c.code = CHAR_SPACE;
            1:       c.code = CHAR_TAB;
            2:       c.code = CHAR_NEWLINE;
            default: c.code = CODE_W'($urandom_range(0, 255));
        endcase
        c.kerning      = pick_field(OFS_W);
        c.glyph_left   = pick_field(OFS_W);
        c.glyph_top    = pick_field(OFS_W);
        c.glyph_width  = SIZE_W'(pick_field(SIZE_W));
        c.glyph_height = SIZE_W'(pick_field(SIZE_W));
        c.tex_left     = TEX_W'(pick_field(TEX_W));
        c.tex_top      = TEX_W'(pick_field(TEX_W));
        c.tex_width    = TEX_W'(pick_field(TEX_W));
        c.tex_height   = TEX_W'(pick_field(TEX_W));
        c.advance      = pick_field(ADV_W);
        c.last         = last;
        return c;
    endfunction

    // Offer one character after a random gap and model it once transferred.
    task automatic send_char(input glyph_char_t c);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_char_code     <= c.code;
        s_kerning       <= c.kerning;
        s_glyph_left    <= c.glyph_left;
        s_glyph_top     <= c.glyph_top;
        s_glyph_width   <= c.glyph_width;
        s_glyph_height  <= c.glyph_height;
        s_tex_left      <= c.tex_left;
        s_tex_top       <= c.tex_top;
        s_tex_width     <= c.tex_width;
        s_tex_height    <= c.tex_height;
        s_glyph_advance <= c.advance;
        s_last_char     <= c.last;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        layout_char(c);
    endtask

    // A string of random characters; now and then a stray end mark splits it.
    task automatic send_string(input int len);
        send_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_char(rand_char(i == len - 1 || $urandom_range(0, 19) == 0));
    endtask

    // Let every expected record come out and the front end go quiet.
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CHAR_SIZE:     char_size_q = data[CHAR_SIZE_W-1:0];
            REG_SPACE_ADVANCE: space_adv_q = data[SPACE_W-1:0];
            REG_LINE_SPACING:  line_step_q = data[LINE_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all_regs(input int size, input int space, input int line);
        write_reg(REG_CHAR_SIZE, CFG_DATA_W'(size));
        write_reg(REG_SPACE_ADVANCE, CFG_DATA_W'(space));
        write_reg(REG_LINE_SPACING, CFG_DATA_W'(line));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A short word with every kind of whitespace under the reset registers.
    task automatic test_reset_defaults();
        send_burst = 1'b0;
        send_char(make_char(8'd84, 0, 64, -768, 512, 768, 10, 20, 8, 12, 640, 1'b0));
        send_char(make_char(CHAR_SPACE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_char(make_char(8'd111, -64, 32, -512, 448, 512, 30, 20, 7, 8, 576, 1'b0));
        send_char(make_char(CHAR_TAB, 16, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_char(make_char(CHAR_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_char(make_char(8'd107, 0, 0, -704, 512, 704, 40, 20, 8, 11, 576, 1'b1));
    endtask

    // Field extremes, lone whitespace strings and codes next to the special ones.
    task automatic test_field_extremes();
        send_char(make_char(8'd0, 32767, 32767, 32767, 32767, 32767,
                            4095, 4095, 4095, 4095, 65535, 1'b0));
        send_char(make_char(8'd255, -32768, -32768, -32768, 0, 0,
                            0, 0, 0, 0, 0, 1'b1));
        send_char(make_char(CHAR_SPACE, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_char(make_char(CHAR_TAB, -100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_char(make_char(CHAR_NEWLINE, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_char(make_char(CHAR_TAB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_char(make_char(8'd8, -1, -1, -1, 1, 1, 1, 1, 1, 1, 1, 1'b0));
        send_char(make_char(8'd11, 300, -200, 100, 900, 700, 2048, 1024, 300, 200,
                            1000, 1'b0));
        send_char(make_char(8'd31, 0, 0, 0, 64, 64, 4095, 0, 4095, 0, 64, 1'b0));
        send_char(make_char(8'd33, 0, 0, 0, 64, 64, 0, 4095, 0, 4095, 64, 1'b1));
        send_char(make_char(8'd65, 0, 10, -10, 20, 20, 5, 5, 5, 5, 30, 1'b1));
    endtask

    // Several register settings, extremes included, each with a short string.
    task automatic test_register_settings();
        int size, space, line;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin size = 0;    space = 0;     line = 0;      end
                1: begin size = 1023; space = 65535; line = 131071; end
                2: begin size = 1;    space = 1;     line = 1;      end
                default: begin
                    size  = $urandom_range(0, 131071);
                    space = $urandom_range(0, 131071);
                    line  = $urandom_range(0, 131071);
                end
            endcase
            wait_drain();
            write_all_regs(size, space, line);
            write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 131071)));
            send_string($urandom_range(2, 8));
        end

        // Writes in the middle of a string: size waits for the next string.
        wait_drain();
        for (int i = 0; i < 3; i++)
            send_char(rand_char(1'b0));
        wait_drain();
        write_all_regs($urandom_range(1, 1023), $urandom_range(0, 65535),
                       $urandom_range(0, 131071));
        for (int i = 0; i < 4; i++)
            send_char(rand_char(i == 3));
        send_string(3);
        wait_drain();
        write_all_regs(int'(CHAR_SIZE_RESET), int'(SPACE_RESET), int'(LINE_RESET));
    endtask

    task automatic test_random_strings();
        repeat (3) send_string($urandom_range(1, 16));
    endtask

    // Drive the pen to both ends of the coordinate range, one string for each.
    task automatic test_coordinate_saturation();
        wait_drain();
        write_reg(REG_SPACE_ADVANCE, '0);
        send_burst = 1'b1;
        repeat (260)
            send_char(make_char(CHAR_SPACE, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_char(make_char(8'd103, -32768, -32768, -32768, 100, 100,
                            1, 2, 3, 4, 0, 1'b1));
        wait_drain();
        write_reg(REG_SPACE_ADVANCE, CFG_DATA_W'(65535));
        write_reg(REG_LINE_SPACING, CFG_DATA_W'(131071));
        send_burst = 1'b1;
        repeat (66)
            send_char(make_char(CHAR_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        repeat (30)
            send_char(make_char(CHAR_TAB, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_char(make_char(8'd77, 32767, 32767, 32767, 32767, 32767,
                            4095, 4095, 4095, 4095, 65535, 1'b1));
        wait_drain();
        write_all_regs(int'(CHAR_SIZE_RESET), int'(SPACE_RESET), int'(LINE_RESET));
    endtask

    // Hold the output off for a long stretch while glyphs keep coming.
    task automatic test_output_backpressure();
        glyph_char_t c;
        hold_request = HOLD_CYCLES;
        send_burst   = 1'b1;
        for (int i = 0; i < 14; i++) begin
            c      = rand_char(i == 13);
            c.code = CODE_W'(65 + $urandom_range(0, 25));
            send_char(c);
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready pattern and record check
    // ------------------------------------------------------------------------

    initial begin : result_sink
        int pause;
        int calm_left;
        calm_left = 0;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end
            // Occasional runs of records taken without any stall.
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 7) == 0)
                calm_left = 24;
            pause = (calm_left > 0) ? 0 : $urandom_range(0, 12);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic void compare_field(input string name,
                                          input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : record_check
        layout_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $error("record transfer with no record expected");
                fail_count++;
            end else begin
                want = expected_records.pop_front();
                compare_field("vertex_x", 32'(want.vertex_x), 32'(m_vertex_x));
                compare_field("vertex_y", 32'(want.vertex_y), 32'(m_vertex_y));
                compare_field("tex_u", 32'(want.tex_u), 32'(m_tex_u));
                compare_field("tex_v", 32'(want.tex_v), 32'(m_tex_v));
                compare_field("is_bounds", 32'(want.is_bounds), 32'(m_is_bounds));
                compare_field("bound_x", 32'(want.bound_x), 32'(m_bound_x));
                compare_field("bound_y", 32'(want.bound_y), 32'(m_bound_y));
                compare_field("bound_w", 32'(want.bound_w), 32'(m_bound_w));
                compare_field("bound_h", 32'(want.bound_h), 32'(m_bound_h));
                compare_field("last_of_run", 32'(want.last_of_run),
                              32'(m_last_of_run));
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("glyph_run_layout verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        s_valid         <= 1'b0;
        s_char_code     <= '0;
        s_kerning       <= '0;
        s_glyph_left    <= '0;
        s_glyph_top     <= '0;
        s_glyph_width   <= '0;
        s_glyph_height  <= '0;
        s_tex_left      <= '0;
        s_tex_top       <= '0;
        s_tex_width     <= '0;
        s_tex_height    <= '0;
        s_glyph_advance <= '0;
        s_last_char     <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        char_size_q = CHAR_SIZE_RESET;
        space_adv_q = SPACE_RESET;
        line_step_q = LINE_RESET;
        restart_layout();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_field_extremes();
        test_register_settings();
        test_random_strings();
        test_coordinate_saturation();
        test_output_backpressure();
        wait_drain();

        if (fail_count == 0 && expected_records.size() == 0)
            $display("glyph_run_layout verification clean");
        else
            $display("glyph_run_layout verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/glr_pkg.sv
hdl/glr_fifo.sv
hdl/glr_front.sv
hdl/glr_back.sv
hdl/glyph_run_layout.sv
bench/tb_top.sv
